### sv/regex_infix_to_postfix_core_defines.svh
// assertion macros used by the converter rtl (ritp_dp)
// clocked on clk, disabled while rst_n is low
`ifndef REGEX_INFIX_TO_POSTFIX_CORE_DEFINES_SVH
`define REGEX_INFIX_TO_POSTFIX_CORE_DEFINES_SVH

// same-cycle implication
`define RITP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RITP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ritp_pkg.sv
// shared constants, types and character helpers for the infix-to-postfix converter
// used by ritp_ctrl, ritp_dp and regex_infix_to_postfix_core
`default_nettype none

package ritp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CHAR_W      = 8;
  localparam int ERR_W       = 2;
  localparam int USER_W      = 4;

  localparam logic [CHAR_W-1:0] CH_LPAR = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;

  typedef logic [1:0] op_t;
  localparam op_t OP_LPAR = 2'd0;
  localparam op_t OP_CAT  = 2'd1;
  localparam op_t OP_ALT  = 2'd2;

  typedef logic [ERR_W-1:0] err_t;
  localparam err_t ERR_NONE      = 2'd0;
  localparam err_t ERR_OVERFLOW  = 2'd1;
  localparam err_t ERR_UNMATCHED = 2'd2;

  typedef struct packed {
    logic load;
    logic pop;
    logic push;
    op_t  push_op;
    logic emit_in;
    logic close;
    logic finalize;
  } dp_cmd_t;

  typedef struct packed {
    logic need_cat;
    logic is_operand;
    logic is_lpar;
    logic is_rpar;
    logic is_plus;
    logic fin;
    logic empty;
    op_t  top_op;
    logic emit_ok;
    logic end_ok;
  } dp_sts_t;

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // a character after which an implicit concatenation may follow
  function automatic logic ends_term(input logic [CHAR_W-1:0] c);
    return is_alpha(c) || c == CH_RPAR || c == CH_STAR;
  endfunction

  function automatic logic starts_term(input logic [CHAR_W-1:0] c);
    return is_alpha(c) || c == CH_LPAR;
  endfunction

  function automatic logic [CHAR_W-1:0] op_char(input op_t op);
    logic [CHAR_W-1:0] c;
    case (op)
      OP_LPAR: c = CH_LPAR;
      OP_CAT:  c = CH_DOT;
      OP_ALT:  c = CH_PLUS;
      default: c = CH_PLUS;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/ritp_ctrl.sv
// sequencing state machine of the converter: one stack step per cycle while the output register is free
// depends on ritp_pkg; drives ritp_dp through dp_cmd_t and reads dp_sts_t
`default_nettype none

module ritp_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire ritp_pkg::dp_sts_t sts,
  output ritp_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CAT   = 3'd1;
  localparam logic [2:0] ST_MAIN  = 3'd2;
  localparam logic [2:0] ST_CLOSE = 3'd3;
  localparam logic [2:0] ST_ALT   = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.push_op  = ritp_pkg::OP_CAT;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.need_cat ? ST_CAT : ST_MAIN;
        end
      end
      ST_CAT: begin
        // pop pending concatenations, then push the implicit one
        if (!sts.empty && sts.top_op == ritp_pkg::OP_CAT) begin
          cmd.pop = sts.emit_ok;
        end else begin
          cmd.push    = 1'b1;
          cmd.push_op = ritp_pkg::OP_CAT;
          state_nxt   = ST_MAIN;
        end
      end
      ST_MAIN: begin
        if (sts.is_operand) begin
          if (sts.emit_ok) begin
            cmd.emit_in = 1'b1;
            state_nxt   = ST_FLUSH;
          end
        end else if (sts.is_lpar) begin
          cmd.push    = 1'b1;
          cmd.push_op = ritp_pkg::OP_LPAR;
          state_nxt   = ST_FLUSH;
        end else if (sts.is_rpar) begin
          state_nxt = ST_CLOSE;
        end else if (sts.is_plus) begin
          state_nxt = ST_ALT;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_CLOSE: begin
        if (!sts.empty && sts.top_op != ritp_pkg::OP_LPAR) begin
          cmd.pop = sts.emit_ok;
        end else begin
          cmd.close = 1'b1;
          state_nxt = ST_FLUSH;
        end
      end
      ST_ALT: begin
        if (!sts.empty &&
            (sts.top_op == ritp_pkg::OP_CAT || sts.top_op == ritp_pkg::OP_ALT)) begin
          cmd.pop = sts.emit_ok;
        end else begin
          cmd.push    = 1'b1;
          cmd.push_op = ritp_pkg::OP_ALT;
          state_nxt   = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (sts.fin && !sts.empty) begin
          cmd.pop = sts.emit_ok;
        end else if (sts.end_ok) begin
          cmd.finalize = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/ritp_dp.sv
// datapath: character register, operator stack, held result and output register
// depends on ritp_pkg and the assertion macros in regex_infix_to_postfix_core_defines.svh
`default_nettype none
`include "regex_infix_to_postfix_core_defines.svh"

module ritp_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire [ritp_pkg::CHAR_W-1:0]       in_char,
  input  wire                              in_fin,
  input  wire ritp_pkg::dp_cmd_t           cmd,
  output ritp_pkg::dp_sts_t                sts,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [ritp_pkg::CHAR_W-1:0]      out_char,
  output logic                             out_last,
  output logic [ritp_pkg::USER_W-1:0]      out_user
);

  logic [ritp_pkg::CHAR_W-1:0] ch_r;
  logic                        fin_r;
  logic                        prev_end_r;
  ritp_pkg::op_t               stack_r [ritp_pkg::STACK_DEPTH];
  logic [ritp_pkg::CNT_W-1:0]  cnt_r;
  ritp_pkg::err_t              err_r;
  logic                        hold_valid_r;
  logic [ritp_pkg::CHAR_W-1:0] hold_char_r;

  logic                        out_valid_r;
  logic [ritp_pkg::CHAR_W-1:0] out_char_r;
  logic                        out_cv_r;
  logic                        out_last_r;
  logic                        out_done_r;
  ritp_pkg::err_t              out_err_r;

  logic [ritp_pkg::CNT_W-1:0]  cnt_m1;
  ritp_pkg::op_t               top_op;
  logic                        empty;
  logic                        full;
  logic                        out_free;
  logic                        emit;
  logic [ritp_pkg::CHAR_W-1:0] emit_char;
  logic                        end_has_item;
  logic                        push_ok;

  assign cnt_m1   = cnt_r - ritp_pkg::CNT_W'(1);
  assign top_op   = stack_r[cnt_m1[ritp_pkg::PTR_W-1:0]];
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == ritp_pkg::CNT_W'(ritp_pkg::STACK_DEPTH));
  assign out_free = !out_valid_r || out_ready;
  assign emit     = cmd.pop || cmd.emit_in;
  assign emit_char = cmd.pop ? ritp_pkg::op_char(top_op) : ch_r;
  assign push_ok  = cmd.push && !full;
  assign end_has_item = hold_valid_r || fin_r || (err_r != ritp_pkg::ERR_NONE);

  always_comb begin
    sts.need_cat   = prev_end_r && ritp_pkg::starts_term(in_char);
    sts.is_operand = ritp_pkg::is_alpha(ch_r) || ritp_pkg::is_digit(ch_r) ||
                     ch_r == ritp_pkg::CH_STAR;
    sts.is_lpar    = (ch_r == ritp_pkg::CH_LPAR);
    sts.is_rpar    = (ch_r == ritp_pkg::CH_RPAR);
    sts.is_plus    = (ch_r == ritp_pkg::CH_PLUS);
    sts.fin        = fin_r;
    sts.empty      = empty;
    sts.top_op     = top_op;
    // the last result of an item is held back until its flags are known
    sts.emit_ok    = !hold_valid_r || out_free;
    sts.end_ok     = !end_has_item || out_free;
  end

  // operator stack entries
  always_ff @(posedge clk) begin
    if (push_ok) begin
      stack_r[cnt_r[ritp_pkg::PTR_W-1:0]] <= cmd.push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r  <= in_char;
      fin_r <= in_fin;
    end
    if (emit) begin
      hold_char_r <= emit_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      err_r        <= ritp_pkg::ERR_NONE;
      prev_end_r   <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      if (cmd.pop) begin
        cnt_r <= cnt_m1;
      end else if (push_ok) begin
        cnt_r <= cnt_r + ritp_pkg::CNT_W'(1);
      end else if (cmd.close && !empty) begin
        cnt_r <= cnt_m1;
      end
      if (cmd.finalize) begin
        err_r <= ritp_pkg::ERR_NONE;
      end else if (err_r == ritp_pkg::ERR_NONE) begin
        if (cmd.push && full) begin
          err_r <= ritp_pkg::ERR_OVERFLOW;
        end else if (cmd.close && empty) begin
          err_r <= ritp_pkg::ERR_UNMATCHED;
        end
      end
      if (cmd.finalize) begin
        prev_end_r   <= !fin_r && ritp_pkg::ends_term(ch_r);
        hold_valid_r <= 1'b0;
      end else if (emit) begin
        hold_valid_r <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if ((emit && hold_valid_r) || (cmd.finalize && end_has_item)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit && hold_valid_r) begin
      out_char_r <= hold_char_r;
      out_cv_r   <= 1'b1;
      out_last_r <= 1'b0;
      out_done_r <= 1'b0;
      out_err_r  <= ritp_pkg::ERR_NONE;
    end else if (cmd.finalize && end_has_item) begin
      out_char_r <= hold_valid_r ? hold_char_r : '0;
      out_cv_r   <= hold_valid_r;
      out_last_r <= 1'b1;
      out_done_r <= fin_r;
      out_err_r  <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign out_user  = {out_err_r, out_done_r, out_cv_r};

  `RITP_ASSERT_IMPL(a_cnt_range, 1'b1,
                    cnt_r <= ritp_pkg::CNT_W'(ritp_pkg::STACK_DEPTH),
                    "stack count beyond depth")
  `RITP_ASSERT_IMPL(a_pop_nonempty, cmd.pop, !empty, "pop from empty stack")
  `RITP_ASSERT_IMPL(a_emit_room, emit && hold_valid_r, out_free,
                    "held item pushed into a busy output register")
  `RITP_ASSERT_NEXT(a_final_clear, cmd.finalize,
                    !hold_valid_r && err_r == ritp_pkg::ERR_NONE,
                    "item state not cleared after its last result")

endmodule

`default_nettype wire

### sv/regex_infix_to_postfix_core.sv
// channel  | dir | tdata            | tuser                                     | tlast
// in_      | in  | [7:0] char       | -                                         | last char
// out_     | out | [7:0] postfix ch | [0] char_valid [1] expr_done [3:2] error  | run_last
//
// one item at a time: an accept step (IDLE), a step for the character itself (MAIN), a closing step (FLUSH),
// plus a step for an implicit concatenation (CAT), one for ')' or '+' (CLOSE, ALT), and one per operator popped
// off the stack (the stack gives one entry per cycle while the output is free); a final item adds its flush pops
// output register stalls hold the sequencer in place; in_tready is high only when idle
// reset (rst_n low, synchronous) empties the stack and forgets the previous character
`default_nettype none

module regex_infix_to_postfix_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire [7:0]                    in_tdata,   // [7:0] in_char
  input  wire                          in_tlast,   // final_char
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [7:0]                   out_tdata,  // [7:0] out_char
  output logic [ritp_pkg::USER_W-1:0]  out_tuser,  // [0] char_valid, [1] expr_done, [3:2] error_code
  output logic                         out_tlast   // run_last
);

  ritp_pkg::dp_cmd_t cmd;
  ritp_pkg::dp_sts_t sts;

  ritp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ritp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_char   (in_tdata),
    .in_fin    (in_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast),
    .out_user  (out_tuser)
  );

endmodule

`default_nettype wire

### bench/tb_regex_infix_to_postfix_core.sv
// self-checking bench for regex_infix_to_postfix_core: directed table, then random expressions
// depends on ritp_pkg for the operator characters, error codes and stack depth
`timescale 1ns / 100ps

module tb_regex_infix_to_postfix_core;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 100;
  localparam int ITEM_TARGET    = 300;

  typedef struct packed {
    logic [7:0]      ch;
    logic            vld;
    logic            run_last;
    logic            done;
    ritp_pkg::err_t  err;
  } postfix_t;

  typedef struct {
    logic [7:0] c;
    logic       fin;
    int         reps;
    bit         pinned;
    postfix_t   want;
  } plan_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [7:0]                    in_tdata;   // [7:0] in_char
  logic                          in_tlast;   // final_char
  logic                          out_tvalid;
  logic                          out_tready;
  logic [7:0]                    out_tdata;  // [7:0] out_char
  logic [ritp_pkg::USER_W-1:0]   out_tuser;  // [0] char_valid, [1] expr_done, [3:2] error_code
  logic                          out_tlast;  // run_last

  // converter state mirrored by the predictor
  logic [7:0]  op_stk [ritp_pkg::STACK_DEPTH];
  int unsigned op_cnt;
  logic [7:0]  prev_in;
  bit          have_prev_in;
  postfix_t    released[$];
  postfix_t    pending_postfix[$];

  int mismatches;
  int items_sent;
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;
  bit hold_served;
  int idle_cycles;

  regex_infix_to_postfix_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] stack_top();
    return (op_cnt == 0) ? 8'h00 : op_stk[op_cnt-1];
  endfunction

  task automatic release_top();
    released.push_back(postfix_t'{stack_top(), 1'b1, 1'b0, 1'b0, ritp_pkg::ERR_NONE});
    op_cnt--;
  endtask

  task automatic push_op(input logic [7:0] op, inout ritp_pkg::err_t err);
    if (op_cnt >= ritp_pkg::STACK_DEPTH) begin
      if (err == ritp_pkg::ERR_NONE) err = ritp_pkg::ERR_OVERFLOW;
    end else begin
      op_stk[op_cnt] = op;
      op_cnt++;
    end
  endtask

  // works out the postfix items released by one infix character
  task automatic convert_char(input logic [7:0] c, input logic fin);
    ritp_pkg::err_t err;
    postfix_t       tail;
    err = ritp_pkg::ERR_NONE;
    released.delete();
    // implicit concatenation, decided before the character itself
    if (have_prev_in && (is_letter(c) || c == ritp_pkg::CH_LPAR) &&
        (is_letter(prev_in) || prev_in == ritp_pkg::CH_RPAR ||
         prev_in == ritp_pkg::CH_STAR)) begin
      while (op_cnt > 0 && (stack_top() == ritp_pkg::CH_DOT ||
                            stack_top() == ritp_pkg::CH_STAR)) release_top();
      push_op(ritp_pkg::CH_DOT, err);
    end
    if (is_letter(c) || is_numeral(c)) begin
      released.push_back(postfix_t'{c, 1'b1, 1'b0, 1'b0, ritp_pkg::ERR_NONE});
    end else if (c == ritp_pkg::CH_LPAR) begin
      push_op(ritp_pkg::CH_LPAR, err);
    end else if (c == ritp_pkg::CH_RPAR) begin
      while (op_cnt > 0 && stack_top() != ritp_pkg::CH_LPAR) release_top();
      if (op_cnt > 0) op_cnt--;
      else if (err == ritp_pkg::ERR_NONE) err = ritp_pkg::ERR_UNMATCHED;
    end else if (c == ritp_pkg::CH_STAR) begin
      released.push_back(postfix_t'{ritp_pkg::CH_STAR, 1'b1, 1'b0, 1'b0,
                                    ritp_pkg::ERR_NONE});
    end else if (c == ritp_pkg::CH_PLUS) begin
      while (op_cnt > 0 && (stack_top() == ritp_pkg::CH_DOT ||
                            stack_top() == ritp_pkg::CH_PLUS)) release_top();
      push_op(ritp_pkg::CH_PLUS, err);
    end
    prev_in = c;
    have_prev_in = 1'b1;
    if (fin) begin
      while (op_cnt > 0) release_top();
      prev_in = 8'h00;
      have_prev_in = 1'b0;
    end
    if (released.size() == 0 && (fin || err != ritp_pkg::ERR_NONE))
      released.push_back(postfix_t'{8'h00, 1'b0, 1'b0, 1'b0, ritp_pkg::ERR_NONE});
    if (released.size() > 0) begin
      tail = released.pop_back();
      tail.run_last = 1'b1;
      tail.done = fin;
      tail.err = err;
      released.push_back(tail);
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int exp_val);
    $display("mismatch on %s: got %0h, expected %0h at %0t", field, got, exp_val, $realtime);
    mismatches++;
  endtask

  // offers one character; pinned rows carry their result typed in
  task automatic send_char(input logic [7:0] c, input logic fin, input bit pinned,
                           input postfix_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    convert_char(c, fin);
    if (pinned) pending_postfix.push_back(want);
    else foreach (released[i]) pending_postfix.push_back(released[i]);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_operand();
    if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
    if ($urandom_range(0, 1) == 0) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  task automatic send_random_expr();
    logic [7:0] chars[$];
    int         depth;
    int         kind;
    int         len;
    bit         broken;
    bit         fin_all;
    depth = 0;
    kind = $urandom_range(0, 19);
    broken = (kind == 1);
    fin_all = 1'b1;
    if (kind == 0) begin
      // lone noise byte
      chars.push_back(8'($urandom_range(0, 255)));
      fin_all = 1'($urandom_range(0, 1));
    end else if (kind == 2) begin
      // nesting from just below to just beyond the stack depth, often enough to fill the stack
      repeat ($urandom_range(ritp_pkg::STACK_DEPTH - 4, ritp_pkg::STACK_DEPTH + 3))
        chars.push_back(ritp_pkg::CH_LPAR);
      chars.push_back(rand_operand());
      chars.push_back(ritp_pkg::CH_LPAR);
      chars.push_back(rand_operand());
    end else begin
      len = $urandom_range(1, 12);
      repeat (len) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: chars.push_back(rand_operand());
          10, 11, 12: begin
            chars.push_back(ritp_pkg::CH_LPAR);
            depth++;
          end
          13, 14: begin
            if (depth > 0 || broken) begin
              chars.push_back(ritp_pkg::CH_RPAR);
              if (depth > 0) depth--;
            end else begin
              chars.push_back(rand_operand());
            end
          end
          15, 16: chars.push_back(ritp_pkg::CH_STAR);
          17, 18: chars.push_back(ritp_pkg::CH_PLUS);
          default: chars.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      if (!broken) begin
        while (depth > 0) begin
          chars.push_back(ritp_pkg::CH_RPAR);
          depth--;
        end
      end else begin
        fin_all = 1'($urandom_range(0, 1));
      end
    end
    foreach (chars[i])
      send_char(chars[i], fin_all && (i == chars.size() - 1), 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk) begin
    postfix_t got;
    postfix_t exp_item;
    if (rst_n && out_tvalid && out_tready) begin
      got = postfix_t'{out_tdata, out_tuser[0], out_tlast, out_tuser[1], out_tuser[3:2]};
      if (pending_postfix.size() == 0) begin
        report_mismatch("unexpected item", got, 0);
      end else begin
        exp_item = pending_postfix.pop_front();
        if (got.ch != exp_item.ch) report_mismatch("out_char", got.ch, exp_item.ch);
        if (got.vld != exp_item.vld) report_mismatch("char_valid", got.vld, exp_item.vld);
        if (got.run_last != exp_item.run_last)
          report_mismatch("run_last", got.run_last, exp_item.run_last);
        if (got.done != exp_item.done) report_mismatch("expr_done", got.done, exp_item.done);
        if (got.err != exp_item.err) report_mismatch("error_code", got.err, exp_item.err);
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served = 1'b1;
      end else begin
        out_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    plan_row_t plan[];
    int        i;
    int        k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    items_sent = 0;
    hold_req = 1'b0;
    tx_idle_pct = 13;
    rx_idle_pct = 49;
    op_cnt = 0;
    prev_in = 8'h00;
    have_prev_in = 1'b0;
    foreach (op_stk[j]) op_stk[j] = 8'h00;

    plan = '{
      '{"a",     1'b0, 1,  1'b1, postfix_t'{"a", 1'b1, 1'b1, 1'b0, ritp_pkg::ERR_NONE}},
      '{ritp_pkg::CH_STAR, 1'b0, 1,  1'b1,
        postfix_t'{ritp_pkg::CH_STAR, 1'b1, 1'b1, 1'b0, ritp_pkg::ERR_NONE}},
      '{"b",     1'b0, 1,  1'b0, postfix_t'('0)},
      '{ritp_pkg::CH_PLUS, 1'b0, 1,  1'b0, postfix_t'('0)},
      '{ritp_pkg::CH_LPAR, 1'b0, 1,  1'b0, postfix_t'('0)},
      '{"0",     1'b0, 1,  1'b0, postfix_t'('0)},
      '{"9",     1'b0, 1,  1'b0, postfix_t'('0)},
      '{ritp_pkg::CH_RPAR, 1'b0, 1,  1'b0, postfix_t'('0)},
      '{ritp_pkg::CH_DOT,  1'b0, 1,  1'b0, postfix_t'('0)},
      '{"z",     1'b1, 1,  1'b0, postfix_t'('0)},
      // close with nothing open
      '{ritp_pkg::CH_RPAR, 1'b0, 1,  1'b1,
        postfix_t'{8'h00, 1'b0, 1'b1, 1'b0, ritp_pkg::ERR_UNMATCHED}},
      '{8'hFF,   1'b1, 1,  1'b1, postfix_t'{8'h00, 1'b0, 1'b1, 1'b1, ritp_pkg::ERR_NONE}},
      // fill the stack to the brim
      '{ritp_pkg::CH_LPAR, 1'b0, ritp_pkg::STACK_DEPTH, 1'b0, postfix_t'('0)},
      '{"A",     1'b0, 1,  1'b1, postfix_t'{"A", 1'b1, 1'b1, 1'b0, ritp_pkg::ERR_NONE}},
      // implicit '.' and '(' both overflow, first one reported
      '{ritp_pkg::CH_LPAR, 1'b0, 1,  1'b1,
        postfix_t'{8'h00, 1'b0, 1'b1, 1'b0, ritp_pkg::ERR_OVERFLOW}},
      '{"Z",     1'b0, 1,  1'b0, postfix_t'('0)},
      '{ritp_pkg::CH_PLUS, 1'b0, 1,  1'b1,
        postfix_t'{8'h00, 1'b0, 1'b1, 1'b0, ritp_pkg::ERR_OVERFLOW}},
      '{8'h00,   1'b1, 1,  1'b0, postfix_t'('0)},
      '{8'h80,   1'b1, 1,  1'b1, postfix_t'{8'h00, 1'b0, 1'b1, 1'b1, ritp_pkg::ERR_NONE}},
      '{"a",     1'b0, 1,  1'b0, postfix_t'('0)},
      '{ritp_pkg::CH_PLUS, 1'b0, 1,  1'b0, postfix_t'('0)},
      '{"b",     1'b0, 1,  1'b0, postfix_t'('0)},
      '{ritp_pkg::CH_RPAR, 1'b0, 1,  1'b0, postfix_t'('0)},
      '{8'h20,   1'b1, 1,  1'b0, postfix_t'('0)},
      '{ritp_pkg::CH_LPAR, 1'b0, 1,  1'b0, postfix_t'('0)},
      '{"a",     1'b0, 1,  1'b0, postfix_t'('0)},
      '{"b",     1'b0, 1,  1'b0, postfix_t'('0)},
      '{ritp_pkg::CH_STAR, 1'b0, 1,  1'b0, postfix_t'('0)},
      '{"c",     1'b0, 1,  1'b0, postfix_t'('0)},
      '{ritp_pkg::CH_RPAR, 1'b1, 1,  1'b0, postfix_t'('0)}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < plan.size(); i++) begin
      for (k = 0; k < plan[i].reps; k++) begin
        send_char(plan[i].c, plan[i].fin && (k == plan[i].reps - 1),
                  plan[i].pinned && (k == plan[i].reps - 1), plan[i].want);
      end
    end

    while (items_sent < ITEM_TARGET) begin
      if (items_sent < 120) begin
        tx_idle_pct = 13;
        rx_idle_pct = 49;
      end else if (items_sent < 230) begin
        tx_idle_pct = 49;
        rx_idle_pct = 13;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
      end
      send_random_expr();
    end
    in_tvalid <= 1'b0;

    while (pending_postfix.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_postfix.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
